/* rtl/labeled_interval_membership_table_unit_defines.svh */
// Assertion macros for the labeled interval membership table unit.
// Used by the top level only; no other dependencies.
`ifndef LABELED_INTERVAL_MEMBERSHIP_TABLE_UNIT_DEFINES_SVH
`define LABELED_INTERVAL_MEMBERSHIP_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define LIMTU_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("limtu assertion failed");
// Check a property on every clock edge, reset included
`define LIMTU_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("limtu assertion failed");
`else
`define LIMTU_ASSERT(label, prop)
`define LIMTU_ASSERT_ALWAYS(label, prop)
`endif
`endif

/* rtl/limtu_pkg.sv */
// Shared types and constants for the labeled interval membership table unit.
// No dependencies.
`default_nettype none
package limtu_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int FRAME_W       = 24;
    localparam int LABEL_W       = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int IN_BITS       = 3 * FRAME_W + LABEL_W;
    localparam int S_TDATA_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W     = 8;

    // Request kinds carried on s_tuser
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CACHE,
        ST_SCAN
    } limtu_state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] low;
        logic [FRAME_W-1:0] high;
        logic [LABEL_W-1:0] tag;
    } limtu_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic add_commit;
        logic rd_cache;
        logic scan_start;
        logic scan_step;
        logic cache_set;
        logic result_load;
        logic result_hit;
        logic result_drop;
    } limtu_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_check;
        logic table_empty;
        logic table_full;
        logic frame_above;
        logic cache_usable;
        logic match;
        logic cmp_valid;
        logic cmp_last;
        logic out_free;
    } limtu_sts_t;

endpackage
`default_nettype wire

/* rtl/limtu_ctrl.sv */
// Controller state machine for the interval table: sequences add, cache probe and scan.
// Depends on limtu_pkg.
`default_nettype none
module limtu_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire limtu_pkg::limtu_sts_t sts,
    output limtu_pkg::limtu_cmd_t     cmd
);
    import limtu_pkg::*;

    limtu_state_t state_reg;
    limtu_state_t state_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decide the next state and the commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!sts.is_check) begin
                    if (sts.out_free) begin
                        cmd.result_load = 1'b1;
                        if (sts.table_full) begin
                            cmd.result_drop = 1'b1;
                        end else begin
                            cmd.add_commit = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end else if (sts.table_empty || sts.frame_above) begin
                    if (sts.out_free) begin
                        cmd.result_load = 1'b1;
                        cmd.result_hit  = sts.table_empty;
                        state_next      = ST_IDLE;
                    end
                end else if (sts.cache_usable) begin
                    cmd.rd_cache = 1'b1;
                    state_next   = ST_CACHE;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_CACHE: begin
                if (sts.match) begin
                    if (sts.out_free) begin
                        cmd.result_load = 1'b1;
                        cmd.result_hit  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (sts.cmp_valid && sts.match) begin
                    if (sts.out_free) begin
                        cmd.result_load = 1'b1;
                        cmd.result_hit  = 1'b1;
                        cmd.cache_set   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else if (sts.cmp_valid && sts.cmp_last) begin
                    if (sts.out_free) begin
                        cmd.result_load = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/limtu_dp.sv */
// Datapath for the interval table: request latch, interval memory, scan pointer,
// cache, highest end tracking and result register. Depends on limtu_pkg.
`default_nettype none
module limtu_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [limtu_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [limtu_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire limtu_pkg::limtu_cmd_t          cmd,
    output limtu_pkg::limtu_sts_t               sts
);
    import limtu_pkg::*;

    // Request fields
    logic                 func_reg;
    logic [FRAME_W-1:0]   lo_reg;
    logic [FRAME_W-1:0]   hi_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [LABEL_W-1:0]   label_reg;

    // Table bookkeeping
    logic [CNT_W-1:0]     count_reg;
    logic [FRAME_W-1:0]   highest_reg;
    logic                 cache_valid_reg;
    logic [IDX_W-1:0]     cache_idx_reg;

    // Scan pointer and compare stage
    logic [CNT_W-1:0]     scan_idx_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic                 cmp_valid_reg;

    // Interval memory
    limtu_entry_t         mem [TABLE_ENTRIES];
    limtu_entry_t         rd_data_reg;
    limtu_entry_t         wr_entry;
    logic [IDX_W-1:0]     rd_addr;
    logic                 rd_en;

    // Result register
    logic                 m_valid_reg;
    logic                 hit_reg;
    logic                 drop_reg;

    logic [FRAME_W-1:0]   in_first;
    logic [FRAME_W-1:0]   in_last;
    logic                 tag_ok;

    assign in_first = s_tdata[FRAME_W-1:0];
    assign in_last  = s_tdata[2*FRAME_W-1:FRAME_W];

    // Latch the request, ordering the bounds
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            func_reg  <= s_tuser;
            lo_reg    <= (in_first > in_last) ? in_last : in_first;
            hi_reg    <= (in_first > in_last) ? in_first : in_last;
            frame_reg <= s_tdata[3*FRAME_W-1:2*FRAME_W];
            label_reg <= s_tdata[3*FRAME_W+LABEL_W-1:3*FRAME_W];
        end
    end

    // Advance the fill count and the highest end on a stored add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            highest_reg <= '0;
        end else if (cmd.add_commit) begin
            count_reg <= count_reg + CNT_W'(1);
            if (hi_reg > highest_reg) begin
                highest_reg <= hi_reg;
            end
        end
    end

    // Remember the lowest entry that hit in the last scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cache_valid_reg <= 1'b0;
            cache_idx_reg   <= '0;
        end else if (cmd.cache_set) begin
            cache_valid_reg <= 1'b1;
            cache_idx_reg   <= cmp_idx_reg;
        end
    end

    // Step the scan pointer; the compare stage trails it by one read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
        end else if (cmd.scan_start) begin
            cmp_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
        end else if (cmd.scan_step) begin
            cmp_valid_reg <= 1'b1;
            cmp_idx_reg   <= scan_idx_reg[IDX_W-1:0];
            scan_idx_reg  <= scan_idx_reg + CNT_W'(1);
        end
    end

    // Write a new interval at the fill position
    assign wr_entry = '{low: lo_reg, high: hi_reg, tag: label_reg};

    always_ff @(posedge aclk) begin
        if (cmd.add_commit) begin
            mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
    end

    // Read one entry per cycle while the scan steps or the cache is probed, either the cached index or the scan pointer
    assign rd_addr = cmd.rd_cache ? cache_idx_reg : scan_idx_reg[IDX_W-1:0];
    assign rd_en   = cmd.rd_cache | cmd.scan_step;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            hit_reg  <= cmd.result_hit;
            drop_reg <= cmd.result_drop;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, drop_reg, hit_reg};

    // Report status to the controller
    assign tag_ok = (label_reg == '0) || (label_reg == rd_data_reg.tag);

    always_comb begin
        sts              = '0;
        sts.is_check     = (func_reg == FUNC_CHECK);
        sts.table_empty  = (count_reg == '0);
        sts.table_full   = (count_reg == CNT_W'(TABLE_ENTRIES));
        sts.frame_above  = (frame_reg > highest_reg);
        sts.cache_usable = cache_valid_reg && (CNT_W'(cache_idx_reg) < count_reg);
        sts.match        = tag_ok && (frame_reg >= rd_data_reg.low)
                           && (frame_reg <= rd_data_reg.high);
        sts.cmp_valid    = cmp_valid_reg;
        sts.cmp_last     = ((CNT_W'(cmp_idx_reg) + CNT_W'(1)) == count_reg);
        sts.out_free     = !m_valid_reg || m_tready;
    end

endmodule
`default_nettype wire

/* rtl/labeled_interval_membership_table_unit.sv */
// Top level of the labeled interval membership table unit.
// Depends on limtu_pkg, limtu_ctrl, limtu_dp and the assertion macro header.
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  s_      | in  | first_frame, last_frame, frame_number, label_id    | func
//  m_      | out | frame_hit, add_dropped, six zero pad bits          | -
//
// One request at a time. An add is answered from ST_DECIDE, as is a check on an empty
// table or above the highest end; a cache hit is answered from ST_CACHE, and a scan from
// ST_SCAN through the single read port of the interval memory, one entry a cycle unless a stalled result holds it.
// Reset clears counts, highest end and cache; entries are only read below the fill count,
// so no clearing pass runs. A stalled result holds the controller until m_tready.
`default_nettype none
`include "labeled_interval_membership_table_unit_defines.svh"
module labeled_interval_membership_table_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // first_frame, last_frame, frame_number, label_id
    input  wire logic [limtu_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // frame_hit, add_dropped, zero pad
    output logic [limtu_pkg::M_TDATA_W-1:0]      m_tdata
);
    import limtu_pkg::*;

    limtu_cmd_t cmd;
    limtu_sts_t sts;

    limtu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    limtu_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Never store into a full table
    `LIMTU_ASSERT(a_no_add_when_full, cmd.add_commit |-> !sts.table_full)
    // Never overwrite a result that is still waiting
    `LIMTU_ASSERT(a_no_result_overrun, cmd.result_load |-> sts.out_free)
    // Cache only takes an entry that was compared and matched
    `LIMTU_ASSERT(a_cache_on_match, cmd.cache_set |-> (sts.cmp_valid && sts.match))
    // One request in flight: no acceptance right after another
    `LIMTU_ASSERT_ALWAYS(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready)

endmodule
`default_nettype wire

/* dv/interval_table_checker.sv */
// Checker for the labeled interval membership table unit: watches both streams,
// predicts every result from its own copy of the interval table and compares.
// Depends on limtu_pkg only.
module interval_table_checker (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    // first_frame, last_frame, frame_number, label_id
    input  wire logic [limtu_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  wire logic                            s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    // frame_hit, add_dropped, zero pad
    input  wire logic [limtu_pkg::M_TDATA_W-1:0] m_tdata,
    output int                                   mismatches,
    output int                                   outstanding,
    output int                                   adds_seen,
    output int                                   drops_seen,
    output int                                   checks_seen,
    output int                                   hits_seen
);
    import limtu_pkg::*;

    typedef struct packed {
        logic is_check;
        logic hit;
        logic dropped;
    } outcome_t;

    // Shadow of the interval table
    logic [FRAME_W-1:0] span_low  [TABLE_ENTRIES];
    logic [FRAME_W-1:0] span_high [TABLE_ENTRIES];
    logic [LABEL_W-1:0] span_tag  [TABLE_ENTRIES];
    int unsigned        span_count;
    logic [FRAME_W-1:0] top_end;
    bit                 cached;
    int unsigned        cached_idx;

    outcome_t pending_outcomes[$];
    outcome_t predicted;
    outcome_t want;

    function automatic bit span_covers(int unsigned idx, logic [FRAME_W-1:0] frame,
                                       logic [LABEL_W-1:0] label);
        if (label != '0 && label != span_tag[idx])
            return 1'b0;
        return frame >= span_low[idx] && frame <= span_high[idx];
    endfunction

    // Apply one request to the shadow table and return the result it causes
    function automatic outcome_t membership_outcome(logic func, logic [FRAME_W-1:0] lo,
                                                    logic [FRAME_W-1:0] hi,
                                                    logic [FRAME_W-1:0] frame,
                                                    logic [LABEL_W-1:0] label);
        outcome_t           res;
        logic [FRAME_W-1:0] tmp;
        int unsigned        i;
        res = '0;
        res.is_check = (func == FUNC_CHECK);
        if (func == FUNC_ADD) begin
            // refuse on a full table, state untouched
            if (span_count >= TABLE_ENTRIES) begin
                res.dropped = 1'b1;
                return res;
            end
            if (lo > hi) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            span_low[span_count]  = lo;
            span_high[span_count] = hi;
            span_tag[span_count]  = label;
            span_count++;
            if (hi > top_end)
                top_end = hi;
            return res;
        end
        if (span_count == 0) begin
            res.hit = 1'b1;
        end else if (frame > top_end) begin
            res.hit = 1'b0;
        end else if (cached && cached_idx < span_count
                     && span_covers(cached_idx, frame, label)) begin
            res.hit = 1'b1;
        end else begin
            // lowest matching index becomes the cached entry
            for (i = 0; i < span_count; i++) begin
                if (span_covers(i, frame, label)) begin
                    res.hit    = 1'b1;
                    cached     = 1'b1;
                    cached_idx = i;
                    break;
                end
            end
        end
        return res;
    endfunction

    // Predict on each accepted request, compare on each accepted result
    always @(posedge aclk) begin
        if (!aresetn) begin
            span_count  = 0;
            top_end     = '0;
            cached      = 1'b0;
            cached_idx  = 0;
            pending_outcomes.delete();
            mismatches  = 0;
            outstanding = 0;
            adds_seen   = 0;
            drops_seen  = 0;
            checks_seen = 0;
            hits_seen   = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted = membership_outcome(s_tuser,
                    s_tdata[FRAME_W-1:0],
                    s_tdata[2*FRAME_W-1:FRAME_W],
                    s_tdata[3*FRAME_W-1:2*FRAME_W],
                    s_tdata[3*FRAME_W+LABEL_W-1:3*FRAME_W]);
                pending_outcomes = {pending_outcomes, predicted};
            end
            if (m_tvalid && m_tready) begin
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: expected no result, got 0x%0h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = pending_outcomes.pop_front();
                    if (m_tdata[0] !== want.hit) begin
                        $display("%0t: frame_hit expected %0b, got %0b",
                                 $time, want.hit, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[1] !== want.dropped) begin
                        $display("%0t: add_dropped expected %0b, got %0b",
                                 $time, want.dropped, m_tdata[1]);
                        mismatches++;
                    end
                    if (m_tdata[M_TDATA_W-1:2] !== '0) begin
                        $display("%0t: pad bits expected 0, got 0x%0h",
                                 $time, m_tdata[M_TDATA_W-1:2]);
                        mismatches++;
                    end
                    if (want.is_check) begin
                        checks_seen++;
                        if (want.hit)
                            hits_seen++;
                    end else begin
                        adds_seen++;
                        if (want.dropped)
                            drops_seen++;
                    end
                end
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

/* dv/testbench.sv */
// Top of the testbench for the labeled interval membership table unit: clock, reset,
// directed and random requests, result back-pressure and the verdict.
// Depends on limtu_pkg, the unit itself and interval_table_checker.
module testbench;
    import limtu_pkg::*;

    localparam int               TOTAL_ITEMS = 700;
    localparam int               STALL_LIMIT = 4000;
    localparam int               TAIL_CYCLES = 80;
    localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // first_frame, last_frame, frame_number, label_id
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // func
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // frame_hit, add_dropped, zero pad
    logic [M_TDATA_W-1:0] m_tdata;

    int mismatches, outstanding, adds_seen, drops_seen, checks_seen, hits_seen;

    int src_idle_pct  = 18;
    int sink_idle_pct = 45;
    int items_sent    = 0;
    int idle_cycles   = 0;

    // Intervals the table should hold, kept only to aim check requests
    logic [FRAME_W-1:0] aim_low[$];
    logic [FRAME_W-1:0] aim_high[$];
    logic [LABEL_W-1:0] aim_tag[$];
    logic [FRAME_W-1:0] aim_top = '0;
    int                 adds_sent = 0;

    always #10 aclk = ~aclk;

    labeled_interval_membership_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    interval_table_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .adds_seen   (adds_seen),
        .drops_seen  (drops_seen),
        .checks_seen (checks_seen),
        .hits_seen   (hits_seen)
    );

    // Stall the result stream at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Abort when no request and no result moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Present one request and hold it until accepted
    task automatic issue_request(logic func, logic [FRAME_W-1:0] first,
                                 logic [FRAME_W-1:0] last, logic [FRAME_W-1:0] frame,
                                 logic [LABEL_W-1:0] label);
        if (items_sent < TOTAL_ITEMS / 3) begin
            src_idle_pct  = 18;
            sink_idle_pct = 45;
        end else if (items_sent < 2 * TOTAL_ITEMS / 3) begin
            src_idle_pct  = 45;
            sink_idle_pct = 18;
        end else begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= S_TDATA_W'({label, frame, last, first});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    task automatic add_interval(logic [FRAME_W-1:0] first, logic [FRAME_W-1:0] last,
                                logic [LABEL_W-1:0] label);
        // frame_number is ignored by an add: fill it with noise
        issue_request(FUNC_ADD, first, last, FRAME_W'($urandom()), label);
        if (adds_sent < TABLE_ENTRIES) begin
            aim_low  = {aim_low, (first < last ? first : last)};
            aim_high = {aim_high, (first < last ? last : first)};
            aim_tag  = {aim_tag, label};
            if (aim_high[$] > aim_top)
                aim_top = aim_high[$];
        end
        adds_sent++;
    endtask

    task automatic check_frame(logic [FRAME_W-1:0] frame, logic [LABEL_W-1:0] label);
        // the bounds are ignored by a check: fill them with noise
        issue_request(FUNC_CHECK, FRAME_W'($urandom()), FRAME_W'($urandom()), frame, label);
    endtask

    // One random request: mostly checks, most of them aimed at stored intervals or their highest end
    task automatic random_request();
        logic [FRAME_W-1:0] lo, hi, frame;
        logic [LABEL_W-1:0] label;
        int unsigned        add_pct, sel, k, span;
        longint             v;
        add_pct = (adds_sent < TABLE_ENTRIES) ? 25 : 8;
        if (aim_low.size() == 0 || $urandom_range(99) < add_pct) begin
            // keep early intervals in the lower range so frames above the end occur
            if (adds_sent >= 40 && $urandom_range(7) == 0)
                lo = FRAME_W'($urandom());
            else
                lo = FRAME_W'($urandom_range(0, 24'hBFFFFF));
            sel = $urandom_range(9);
            if (sel < 5)
                span = $urandom_range(0, 15);
            else if (sel < 9)
                span = $urandom_range(0, 4095);
            else
                span = $urandom_range(0, FRAME_MAX);
            v  = longint'(lo) + span;
            hi = (v > FRAME_MAX) ? FRAME_MAX : FRAME_W'(v);
            label = ($urandom_range(9) < 7) ? LABEL_W'($urandom_range(0, 7))
                                            : LABEL_W'($urandom_range(0, 255));
            if ($urandom_range(9) < 3)
                add_interval(hi, lo, label);
            else
                add_interval(lo, hi, label);
        end else begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                // near or inside one stored interval, bounds included
                k = $urandom_range(0, aim_low.size() - 1);
                v = longint'(aim_low[k]) - 2
                    + $urandom_range(0, aim_high[k] - aim_low[k] + 4);
                frame = (v < 0) ? '0 : (v > FRAME_MAX) ? FRAME_MAX : FRAME_W'(v);
                sel = $urandom_range(9);
                if (sel < 4)
                    label = aim_tag[k];
                else if (sel < 7)
                    label = '0;
                else
                    label = LABEL_W'($urandom_range(0, 7));
            end else begin
                if (sel < 75) begin
                    // around the highest stored end
                    v     = longint'(aim_top) - 2 + $urandom_range(0, 4);
                    frame = (v < 0) ? '0 : (v > FRAME_MAX) ? FRAME_MAX : FRAME_W'(v);
                end else begin
                    frame = FRAME_W'($urandom());
                end
                label = $urandom_range(1) ? '0 : LABEL_W'($urandom_range(0, 255));
            end
            check_frame(frame, label);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table: everything hits
        check_frame(24'h000000, 8'h00);
        check_frame(FRAME_MAX, 8'hFF);
        // swapped bounds
        add_interval(24'h000200, 24'h000100, 8'h03);
        // above the highest end
        check_frame(24'h000201, 8'h00);
        check_frame(FRAME_MAX, 8'h00);
        // bounds, below, label mismatch, repeat hits through the cache
        check_frame(24'h000100, 8'h03);
        check_frame(24'h000200, 8'h00);
        check_frame(24'h0000FF, 8'h00);
        check_frame(24'h000150, 8'h04);
        check_frame(24'h000150, 8'h03);
        check_frame(24'h000150, 8'h03);
        // stored label zero only answers a wildcard query
        add_interval(24'h000000, 24'h000000, 8'h00);
        check_frame(24'h000000, 8'h00);
        check_frame(24'h000000, 8'h05);
        // single-frame interval, gap between intervals, cache moved away and back
        add_interval(24'h000400, 24'h000400, 8'hFF);
        check_frame(24'h000300, 8'h00);
        check_frame(24'h000400, 8'hFF);
        check_frame(24'h000400, 8'h00);
        check_frame(24'h000150, 8'h03);
        // wide swapped interval raising the end
        add_interval(24'h7FFFFF, 24'h555555, 8'h80);
        check_frame(24'h800000, 8'h80);
        check_frame(24'h7FFFFF, 8'h80);
        check_frame(24'h555554, 8'h80);

        while (items_sent < TOTAL_ITEMS)
            random_request();

        // drain the results, then let the block settle
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("Sent %0d requests: %0d adds (%0d refused on a full table),",
                 items_sent, adds_seen, drops_seen);
        $display("%0d checks (%0d hits); covered empty-table checks, frames above the end,",
                 checks_seen, hits_seen);
        $display("label filtering and stalls on both streams.");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/limtu_pkg.sv
rtl/limtu_ctrl.sv
rtl/limtu_dp.sv
rtl/labeled_interval_membership_table_unit.sv
dv/interval_table_checker.sv
dv/testbench.sv
